### rtl/rqbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqbd_pkg
// Shared constants, tables and arithmetic helpers for the RGB quantizer
// with 4x4 ordered dither.
// ----------------------------------------------------------------------------
package rqbd_pkg;

  localparam int unsigned LEV5 = 31;
  localparam int unsigned LEV6 = 63;

  // apb register indexes
  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_DITHER = 1'b1
  } reg_idx_e;

  typedef logic [3:0]        bayer_row_t [4];
  typedef bayer_row_t        bayer_tab_t [4];
  typedef logic signed [3:0] dith_ofs_t  [16];
  typedef logic [7:0]        exp5_tab_t  [32];
  typedef logic [7:0]        exp6_tab_t  [64];

  localparam bayer_tab_t BAYER = '{
    '{4'd0,  4'd8,  4'd2,  4'd10},
    '{4'd12, 4'd4,  4'd14, 4'd6},
    '{4'd3,  4'd11, 4'd1,  4'd9},
    '{4'd15, 4'd7,  4'd13, 4'd5}
  };

  // floor(255*(2B-15)/(32*31)) per bayer level
  localparam dith_ofs_t DITH5_OFS = '{
    -4'sd4, -4'sd4, -4'sd3, -4'sd3, -4'sd2, -4'sd2, -4'sd1, -4'sd1,
    4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd2,  4'sd2,  4'sd3,  4'sd3
  };

  // floor(255*(2B-15)/(32*63)) per bayer level
  localparam dith_ofs_t DITH6_OFS = '{
    -4'sd2, -4'sd2, -4'sd2, -4'sd2, -4'sd1, -4'sd1, -4'sd1, -4'sd1,
    4'sd0,  4'sd0,  4'sd0,  4'sd0,  4'sd1,  4'sd1,  4'sd1,  4'sd1
  };

  function automatic exp5_tab_t build_exp5();
    exp5_tab_t t;
    for (int i = 0; i < 32; i++) begin
      t[i] = 8'((i * 255) / LEV5);
    end
    return t;
  endfunction

  function automatic exp6_tab_t build_exp6();
    exp6_tab_t t;
    for (int i = 0; i < 64; i++) begin
      t[i] = 8'((i * 255) / LEV6);
    end
    return t;
  endfunction

  localparam exp5_tab_t EXP5 = build_exp5();
  localparam exp6_tab_t EXP6 = build_exp6();

  // add a signed offset and clamp to 0..255
  function automatic logic [7:0] dither_add(logic [7:0] v, logic signed [3:0] o);
    logic signed [9:0] s;
    s = $signed({2'b00, v}) + 10'(o);
    if (s < 0) begin
      return 8'd0;
    end else if (s > 10'sd255) begin
      return 8'd255;
    end else begin
      return s[7:0];
    end
  endfunction

  // floor(x/255) for x below 16320
  function automatic logic [5:0] div255(logic [13:0] x);
    logic [13:0] s;
    s = x + 14'd1 + {8'd0, x[13:8]};
    return s[13:8];
  endfunction

endpackage

### rtl/rgb_quantize_bayer_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_quantize_bayer_dither
// RGB888 to RGB555/RGB565 quantizer with optional 4x4 ordered dither,
// giving the packed word and the channels expanded back to 8 bits.
// ----------------------------------------------------------------------------
//  channel   dir  contents
//  s_axis    in   tdata[27:0]: red, green, blue, column phase, row phase
//  m_axis    out  tdata[39:0]: packed color, red, green, blue
//  apb       in   reg 0 format select @0x0, reg 1 dither enable @0x4
//
//  one beat per clock sustained while m_axis is ready; each beat passes
//  through the dither, quantize and expand/pack register stages
//  reset clears the stage valid bits and loads format 565, dither off
//  a stall on m_axis holds the output register; upstream stages keep
//  filling until every stage is full
// ----------------------------------------------------------------------------
module rgb_quantize_bayer_dither (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [25:24] column_phase,
  // [27:26] row_phase, [31:28] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] packed_color, [23:16] red_out, [31:24] green_out, [39:32] blue_out
  output logic [39:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rqbd_pkg::*;

  logic fmt_q, dith_q;
  logic cfg_wr;
  reg_idx_e cfg_idx;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  logic [7:0] r1_d, g1_d, b1_d, r1_q, g1_q, b1_q;
  logic [3:0] bay;
  logic signed [3:0] ofs5, ofsg;

  logic [13:0] xr, xg, xb;
  logic [4:0] qr2_q, qb2_q;
  logic [5:0] qg2_q, qg_d;
  logic [5:0] qr_full, qb_full;

  logic [15:0] pack_d;
  logic [7:0]  rout_d, gout_d, bout_d;
  logic [39:0] out_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q  <= 1'b1;
      dith_q <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_FORMAT: fmt_q  <= pwdata[0];
        REG_DITHER: dith_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FORMAT: prdata = {31'd0, fmt_q};
      REG_DITHER: prdata = {31'd0, dith_q};
      default:    prdata = 32'd0;
    endcase
  end

  // pipeline flow control
  assign en3 = !v3_q || m_axis_tready;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign m_axis_tvalid = v3_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // stage 1: dither offset and clamp when dither is enabled
  always_comb begin
    bay  = BAYER[s_axis_tdata[27:26]][s_axis_tdata[25:24]];
    ofs5 = DITH5_OFS[bay];
    ofsg = fmt_q ? DITH6_OFS[bay] : DITH5_OFS[bay];
    if (dith_q) begin
      r1_d = dither_add(s_axis_tdata[7:0], ofs5);
      g1_d = dither_add(s_axis_tdata[15:8], ofsg);
      b1_d = dither_add(s_axis_tdata[23:16], ofs5);
    end else begin
      r1_d = s_axis_tdata[7:0];
      g1_d = s_axis_tdata[15:8];
      b1_d = s_axis_tdata[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      r1_q <= r1_d;
      g1_q <= g1_d;
      b1_q <= b1_d;
    end
  end

  // stage 2: quantize, v*L/255 with L as shift minus value
  always_comb begin
    xr = {1'b0, r1_q, 5'd0} - {6'd0, r1_q};
    xb = {1'b0, b1_q, 5'd0} - {6'd0, b1_q};
    xg = fmt_q ? ({g1_q, 6'd0} - {6'd0, g1_q})
               : ({1'b0, g1_q, 5'd0} - {6'd0, g1_q});
    qr_full = div255(xr);
    qb_full = div255(xb);
    qg_d    = div255(xg);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      qr2_q <= qr_full[4:0];
      qg2_q <= qg_d;
      qb2_q <= qb_full[4:0];
    end
  end

  // stage 3: expand and pack
  always_comb begin
    rout_d = EXP5[qr2_q];
    bout_d = EXP5[qb2_q];
    if (fmt_q) begin
      gout_d = EXP6[qg2_q];
      pack_d = {qr2_q, qg2_q, qb2_q};
    end else begin
      gout_d = EXP5[qg2_q[4:0]];
      pack_d = {1'b0, qr2_q, qg2_q[4:0], qb2_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      out_q <= {bout_d, gout_d, rout_d, pack_d};
    end
  end

`ifndef ASSERT_OFF
  a_555_msb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !fmt_q) |-> !m_axis_tdata[15])
    else $error("rgb555 word has bit 15 set");

  a_red_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fmt_q ? (m_axis_tdata[15:11] == m_axis_tdata[23:19])
                             : (m_axis_tdata[14:10] == m_axis_tdata[23:19])))
    else $error("expanded red does not match packed red code");

  a_green_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (fmt_q ? (m_axis_tdata[10:5] == m_axis_tdata[31:26])
                             : (m_axis_tdata[9:5] == m_axis_tdata[31:27])))
    else $error("expanded green does not match packed green code");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted beat did not enter the first stage");
`endif

endmodule
